// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hashed request id table RTL.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds in every cycle outside reset.
`define HRIT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define HRIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define HRIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/hrit_pkg.sv =====
// Types and constants of the hashed request id table.
// No dependencies; used by the table, hasher, cell and test files.
`timescale 1ns / 1ps
`default_nettype none

package hrit_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_MULT = 32'h0100_0193;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_HASH = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Search token that walks the row of slot cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic        match_seen;
    logic        free_seen;
    logic [31:0] match_handle;
  } probe_t;

  // Update broadcast to every cell once a search has finished.
  typedef struct packed {
    logic        insert;
    logic        extract;
    logic [31:0] key;
    logic [31:0] handle;
  } commit_t;

endpackage

`default_nettype wire

// ===== hdl/hrit_req_if.sv =====
// Request channel of the hashed request id table.
// Carries the handshake and the request fields; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hrit_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [63:0] seq_num;
  logic        [63:0] guid_low;
  logic        [63:0] guid_high;
  logic        [31:0] query_handle;

  modport source (
    output valid, kind, seq_num, guid_low, guid_high, query_handle,
    input  ready
  );

  modport sink (
    input  valid, kind, seq_num, guid_low, guid_high, query_handle,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/hrit_rsp_if.sv =====
// Response channel of the hashed request id table.
// Carries the handshake and the result fields; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hrit_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] handle_out;
  logic [31:0] key_hash;

  modport source (
    output valid, status, handle_out, key_hash,
    input  ready
  );

  modport sink (
    input  valid, status, handle_out, key_hash,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/hashed_request_id_table.sv =====
// Flow: the sequence number and id bytes are hashed, the search token is launched and crosses
// the row of slot cells, and the result is registered in tail_q and then in the response
// register once that register is free.
// A new request is taken once the previous one has been committed, while its response may
// still wait in the output register.
// Reset: synchronous and active high; it empties every slot and drops any request in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hashed_request_id_table #(
  parameter int SLOT_COUNT = 16,
  parameter int GUID_BYTES = 16
) (
  input  logic clk,
  input  logic rst,
  hrit_req_if.sink   req,
  hrit_rsp_if.source rsp
);
  import hrit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t      state;
  logic        kind_q;
  logic [31:0] handle_q;
  logic [31:0] hash_q;
  probe_t      head;
  probe_t      tail_q;
  probe_t      chain [SLOT_COUNT+1];
  commit_t     commit_q;
  logic        hash_done;
  logic [31:0] hash;
  logic        accept;

  logic        rsp_valid_q;
  status_t     rsp_status_q;
  logic [31:0] rsp_handle_q;
  logic [31:0] rsp_hash_q;

  status_t     result_status;
  logic [31:0] result_handle;
  logic        do_insert;
  logic        do_extract;

  assign req.ready      = (state == S_IDLE);
  assign accept         = req.valid && req.ready;
  assign rsp.valid      = rsp_valid_q;
  assign rsp.status     = rsp_status_q;
  assign rsp.handle_out = rsp_handle_q;
  assign rsp.key_hash   = rsp_hash_q;

  hrit_hash #(
    .GUID_BYTES (GUID_BYTES)
  ) u_hash (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .seq_num   (req.seq_num),
    .guid_low  (req.guid_low),
    .guid_high (req.guid_high),
    .done      (hash_done),
    .hash      (hash)
  );

  assign chain[0] = head;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    hrit_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .commit    (commit_q)
    );
  end

  always_comb begin
    result_status = ST_NOT_FOUND;
    result_handle = 32'd0;
    do_insert     = 1'b0;
    do_extract    = 1'b0;
    if (kind_q == KIND_INSERT) begin
      if (hash_q == 32'd0) begin
        result_status = ST_ZERO_HASH;
      end else if (tail_q.match_seen) begin
        result_status = ST_DUPLICATE;
      end else if (tail_q.free_seen) begin
        result_status = ST_OK;
        do_insert     = 1'b1;
      end else begin
        result_status = ST_FULL;
      end
    end else if ((hash_q != 32'd0) && tail_q.match_seen) begin
      result_status = ST_OK;
      result_handle = tail_q.match_handle;
      do_extract    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      commit_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      head.valid       <= 1'b0;
      commit_q.insert  <= 1'b0;
      commit_q.extract <= 1'b0;
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_q   <= req.kind;
            handle_q <= req.query_handle;
            state    <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            hash_q <= hash;
            head   <= '{valid: 1'b1, key: hash, match_seen: 1'b0, free_seen: 1'b0,
                        match_handle: 32'd0};
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[SLOT_COUNT].valid) begin
            tail_q <= chain[SLOT_COUNT];
            state  <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q      <= 1'b1;
            rsp_status_q     <= result_status;
            rsp_handle_q     <= result_handle;
            rsp_hash_q       <= hash_q;
            commit_q.insert  <= do_insert;
            commit_q.extract <= do_extract;
            commit_q.key     <= hash_q;
            commit_q.handle  <= handle_q;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HRIT_ASSERT_NEXT(a_one_at_a_time, accept, !req.ready)
  `HRIT_ASSERT_ALWAYS(a_commit_exclusive, !(commit_q.insert && commit_q.extract))
  `HRIT_ASSERT_SAME(a_insert_reported, commit_q.insert,
    rsp.valid && (rsp.status == ST_OK) && (rsp.key_hash == commit_q.key))
  `HRIT_ASSERT_SAME(a_zero_hash_status, rsp.valid && (rsp.status == ST_ZERO_HASH),
    rsp.key_hash == 32'd0)

endmodule

`default_nettype wire

// ===== hdl/hrit_hash.sv =====
// Iterative FNV-1a hasher, one byte per cycle over the sequence number and id bytes.
// Depends on hrit_pkg for the hash constants.
`timescale 1ns / 1ps
`default_nettype none

module hrit_hash #(
  parameter int GUID_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] seq_num,
  input  logic        [63:0] guid_low,
  input  logic        [63:0] guid_high,
  output logic               done,
  output logic        [31:0] hash
);
  import hrit_pkg::*;

  localparam int HASH_STEPS = 8 + GUID_BYTES;
  localparam int DATA_W     = 8 * HASH_STEPS;
  localparam int CNT_W      = $clog2(HASH_STEPS + 1);

  logic [191:0]      all_bytes;
  logic [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]  count_q;
  logic              running_q;
  logic [31:0]       mixed;
  logic [31:0]       hash_next;

  assign all_bytes = {guid_high, guid_low, seq_num};
  assign mixed     = hash ^ {24'd0, data_q[7:0]};
  assign hash_next = mixed * HASH_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_q <= 1'b0;
      done      <= 1'b0;
      count_q   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running_q <= 1'b1;
        count_q   <= CNT_W'(HASH_STEPS);
        hash      <= FNV_BASIS;
        data_q    <= all_bytes[DATA_W-1:0];
      end else if (running_q) begin
        hash    <= hash_next;
        data_q  <= data_q >> 8;
        count_q <= count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          running_q <= 1'b0;
          done      <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrit_cell.sv =====
// One slot of the table: holds a key and a handle and examines the passing search token.
// Depends on hrit_pkg for the token and update types.
`timescale 1ns / 1ps
`default_nettype none

module hrit_cell (
  input  logic             clk,
  input  logic             rst,
  input  hrit_pkg::probe_t  probe_in,
  output hrit_pkg::probe_t  probe_out,
  input  hrit_pkg::commit_t commit
);
  import hrit_pkg::*;

  logic [31:0] key_q;
  logic [31:0] handle_q;
  logic        mark_match;
  logic        mark_free;
  logic        hit;
  logic        empty;

  assign empty = (key_q == 32'd0);
  assign hit   = probe_in.valid && (probe_in.key != 32'd0) && (key_q == probe_in.key)
                 && !probe_in.match_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q      <= '0;
      mark_match <= 1'b0;
      mark_free  <= 1'b0;
      probe_out  <= '0;
    end else begin
      probe_out.valid        <= probe_in.valid;
      probe_out.key          <= probe_in.key;
      probe_out.match_seen   <= probe_in.match_seen || hit;
      probe_out.free_seen    <= probe_in.free_seen || empty;
      probe_out.match_handle <= hit ? handle_q : probe_in.match_handle;
      if (probe_in.valid) begin
        mark_match <= hit;
        mark_free  <= empty && !probe_in.free_seen;
      end
      if (commit.insert && mark_free) begin
        key_q <= commit.key;
      end else if (commit.extract && mark_match) begin
        key_q <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.insert && mark_free) begin
      handle_q <= commit.handle;
    end
  end

endmodule

`default_nettype wire

// ===== dv/hashed_request_id_table_test.sv =====
// Self-checking test of the hashed request id table: a directed table of requests, then
// random insert and extract traffic with idling on both channels, checked beat by beat.
// Depends on hrit_pkg, the two channel interfaces and the hashed_request_id_table RTL.
`timescale 1ns / 1ps

module hashed_request_id_table_test;
  import hrit_pkg::*;

  localparam int SLOTS = 16;
  localparam int ID_BYTES = 24;
  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_SIZE = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_LIMIT = 200;
  localparam int TX_IDLE [3] = '{28, 67, 0};
  localparam int RX_IDLE [3] = '{67, 28, 0};
  localparam int INSERT_BIAS [3] = '{30, 55, 80};

  typedef struct {
    logic               kind;
    logic signed [63:0] seq_num;
    logic        [63:0] guid_low;
    logic        [63:0] guid_high;
    logic        [31:0] query_handle;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] handle_out;
    logic [31:0] key_hash;
  } response_t;

  typedef struct {
    logic               kind;
    bit                 use_zero_id;
    logic signed [63:0] seq_num;
    logic        [63:0] guid_low;
    logic        [63:0] guid_high;
    logic        [31:0] query_handle;
    bit                 pinned;
    status_t            status;
    logic        [31:0] handle_out;
  } directed_row_t;

  logic clk;
  logic rst;

  hrit_req_if req_ch ();
  hrit_rsp_if rsp_ch ();

  hashed_request_id_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [31:0]  slot_keys [SLOTS];
  logic [31:0]  slot_handles [SLOTS];
  logic [191:0] slot_ids [SLOTS];
  response_t    pending_responses [$];
  request_t     id_pool [POOL_SIZE];
  logic [191:0] zero_ids [2];
  int           failures = 0;
  int           phase = 0;
  bit           pressure_armed = 0;

  directed_row_t directed_rows [0:24] = '{
    '{KIND_EXTRACT, 0, 64'h0, 64'h0, 64'h0, 32'h0, 1, ST_NOT_FOUND, 32'h0},
    '{KIND_INSERT, 0, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'h0, 64'h0, 64'h0, 32'h0000_1234, 1, ST_DUPLICATE, 32'h0},
    '{KIND_INSERT, 0, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      32'hA5A5_A5A5, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 1, 64'h0, 64'h0, 64'h0, 32'h0000_5A5A, 1, ST_ZERO_HASH, 32'h0},
    '{KIND_EXTRACT, 1, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 32'h0},
    '{KIND_EXTRACT, 0, 64'h0, 64'h0, 64'h0, 32'h0, 1, ST_OK, 32'hFFFF_FFFF},
    '{KIND_EXTRACT, 0, 64'h0, 64'h0, 64'h0, 32'h0, 1, ST_NOT_FOUND, 32'h0},
    '{KIND_INSERT, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 0, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd1, 64'h0, 64'h0, 32'd101, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd2, 64'h0, 64'h0, 32'd102, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd3, 64'h0, 64'h0, 32'd103, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd4, 64'h0, 64'h0, 32'd104, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd5, 64'h0, 64'h0, 32'd105, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd6, 64'h0, 64'h0, 32'd106, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd7, 64'h0, 64'h0, 32'd107, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd8, 64'h0, 64'h0, 32'd108, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd9, 64'h0, 64'h0, 32'd109, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd10, 64'h0, 64'h0, 32'd110, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd11, 64'h0, 64'h0, 32'd111, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd12, 64'h0, 64'h0, 32'd112, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd13, 64'h0, 64'h0, 32'd113, 1, ST_OK, 32'h0},
    '{KIND_INSERT, 0, 64'd14, 64'h0, 64'h0, 32'd114, 1, ST_FULL, 32'h0},
    '{KIND_EXTRACT, 0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      32'h0, 1, ST_OK, 32'hA5A5_A5A5}
  };

  function automatic logic [31:0] fnv_run(input logic [31:0] basis, input logic [191:0] id,
                                          input int first, input int count);
    logic [31:0] acc;
    acc = basis;
    for (int i = first; i < first + count; i++) begin
      acc = (acc ^ {24'd0, id[8*i +: 8]}) * HASH_MULT;
    end
    return acc;
  endfunction

  // Meet in the middle: the last three bytes are worked backwards from a zero hash, so only
  // the byte before them has to be searched for each random prefix.
  function automatic logic [191:0] find_zero_hash_id();
    logic [31:0]  inv;
    logic [31:0]  h20;
    logic [31:0]  h21;
    logic [31:0]  h21_target;
    logic [31:0]  h22;
    logic [15:0]  pair;
    logic [7:0]   b22;
    logic [7:0]   b23;
    logic [191:0] id;
    logic [15:0]  tails [logic [23:0]];
    inv = HASH_MULT;
    repeat (5) inv = inv * (32'd2 - HASH_MULT * inv);
    for (int a = 0; a < 256; a++) begin
      for (int b = 0; b < 256; b++) begin
        h22 = (32'(a) * inv) ^ 32'(b);
        h21_target = h22 * inv;
        tails[h21_target[31:8]] = {a[7:0], b[7:0]};
      end
    end
    repeat (256) begin
      id = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      h20 = fnv_run(FNV_BASIS, id, 0, 20);
      for (int c = 0; c < 256; c++) begin
        h21 = (h20 ^ 32'(c)) * HASH_MULT;
        if (tails.exists(h21[31:8])) begin
          pair = tails[h21[31:8]];
          b23 = pair[15:8];
          b22 = pair[7:0];
          h22 = ({24'd0, b23} * inv) ^ {24'd0, b22};
          h21_target = h22 * inv;
          id[167:160] = c[7:0];
          id[175:168] = h21[7:0] ^ h21_target[7:0];
          id[183:176] = b22;
          id[191:184] = b23;
          if (fnv_run(FNV_BASIS, id, 0, ID_BYTES) == 32'd0) return id;
        end
      end
    end
    return '0;
  endfunction

  function automatic request_t id_request(input logic [191:0] id);
    request_t r;
    r.kind = KIND_INSERT;
    r.seq_num = id[63:0];
    r.guid_low = id[127:64];
    r.guid_high = id[191:128];
    r.query_handle = 32'h0;
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    case ($urandom_range(15))
      0: w = 64'h0;
      1: w = 64'hFFFF_FFFF_FFFF_FFFF;
      2: w = 64'h8000_0000_0000_0000;
      3: w = 64'h7FFF_FFFF_FFFF_FFFF;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic request_t random_id();
    return id_request({random_word(), random_word(), random_word()});
  endfunction

  // Table behaviour: hash the id, search the slots for the key and the first free slot, then update.
  function automatic response_t apply_request(input request_t r);
    response_t    res;
    logic [191:0] id;
    int           hit;
    int           free_slot;
    id = {r.guid_high, r.guid_low, r.seq_num};
    res.key_hash = fnv_run(FNV_BASIS, id, 0, ID_BYTES);
    res.handle_out = 32'h0;
    hit = -1;
    free_slot = -1;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_keys[s] == res.key_hash) hit = s;
      if (slot_keys[s] == 32'h0) free_slot = s;
    end
    if (r.kind == KIND_INSERT) begin
      if (res.key_hash == 32'h0) begin
        res.status = ST_ZERO_HASH;
      end else if (hit >= 0) begin
        res.status = ST_DUPLICATE;
      end else if (free_slot >= 0) begin
        slot_keys[free_slot] = res.key_hash;
        slot_handles[free_slot] = r.query_handle;
        slot_ids[free_slot] = id;
        res.status = ST_OK;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (res.key_hash != 32'h0 && hit >= 0) begin
        slot_keys[hit] = 32'h0;
        res.handle_out = slot_handles[hit];
        res.status = ST_OK;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    return res;
  endfunction

  // Most requests reuse a fixed pool of ids or ids now held in the table, so that duplicates,
  // hits and a full table are common; the rest are fresh ids and ids that hash to zero.
  function automatic request_t next_random_request(input int insert_pct);
    request_t r;
    logic     kind;
    int       pick;
    int       s;
    pick = $urandom_range(99);
    s = $urandom_range(SLOTS - 1);
    kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT;
    if (kind == KIND_INSERT) begin
      if (pick < 78) r = id_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 93) r = random_id();
      else r = id_request(zero_ids[$urandom_range(1)]);
    end else begin
      if (pick < 50) r = id_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 80 && slot_keys[s] != 32'h0) r = id_request(slot_ids[s]);
      else if (pick < 80) r = id_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 95) r = random_id();
      else r = id_request(zero_ids[$urandom_range(1)]);
    end
    r.kind = kind;
    case ($urandom_range(7))
      0: r.query_handle = 32'h0;
      1: r.query_handle = 32'hFFFF_FFFF;
      default: r.query_handle = $urandom;
    endcase
    return r;
  endfunction

  task automatic offer(input request_t r, input bit pinned, input status_t status,
                       input logic [31:0] handle_out);
    response_t exp;
    if ($urandom_range(99) < TX_IDLE[phase]) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < TX_IDLE[phase]);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.seq_num <= r.seq_num;
    req_ch.guid_low <= r.guid_low;
    req_ch.guid_high <= r.guid_high;
    req_ch.query_handle <= r.query_handle;
    do @(posedge clk); while (!req_ch.ready);
    exp = apply_request(r);
    if (pinned) begin
      exp.status = status;
      exp.handle_out = handle_out;
    end
    pending_responses.push_back(exp);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    request_t r;
    int       insert_pct;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_INSERT;
    req_ch.seq_num <= 64'h0;
    req_ch.guid_low <= 64'h0;
    req_ch.guid_high <= 64'h0;
    req_ch.query_handle <= 32'h0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_keys[s] = 32'h0;
      slot_handles[s] = 32'h0;
      slot_ids[s] = '0;
    end
    zero_ids[0] = find_zero_hash_id();
    zero_ids[1] = find_zero_hash_id();
    for (int p = 0; p < POOL_SIZE; p++) id_pool[p] = random_id();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].use_zero_id) begin
        r = id_request(zero_ids[0]);
      end else begin
        r = id_request({directed_rows[i].guid_high, directed_rows[i].guid_low,
                        directed_rows[i].seq_num});
      end
      r.kind = directed_rows[i].kind;
      r.query_handle = directed_rows[i].query_handle;
      offer(r, directed_rows[i].pinned, directed_rows[i].status, directed_rows[i].handle_out);
    end

    insert_pct = INSERT_BIAS[1];
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) insert_pct = INSERT_BIAS[$urandom_range(2)];
      phase = n * 3 / RANDOM_ITEMS;
      if (phase == 2) pressure_armed = 1'b1;
      offer(next_random_request(insert_pct), 1'b0, ST_OK, 32'h0);
    end
    req_ch.valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    response_t exp;
    int        hold_left;
    bit        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_responses.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("%0t: unexpected beat, expected none, actual status %0d handle %h hash %h",
                     $time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.key_hash);
          end
        end else begin
          exp = pending_responses.pop_front();
          if (rsp_ch.status !== exp.status) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_ch.status);
            end
          end
          if (rsp_ch.handle_out !== exp.handle_out) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: handle_out expected %h actual %h", $time, exp.handle_out,
                       rsp_ch.handle_out);
            end
          end
          if (rsp_ch.key_hash !== exp.key_hash) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: key_hash expected %h actual %h", $time, exp.key_hash,
                       rsp_ch.key_hash);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (pressure_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= RX_IDLE[phase]);
      end
      @(posedge clk);
    end
  end

endmodule

// ===== hashed_request_id_table.f =====
+incdir+hdl
hdl/hrit_pkg.sv
hdl/hrit_req_if.sv
hdl/hrit_rsp_if.sv
hdl/hrit_hash.sv
hdl/hrit_cell.sv
hdl/hashed_request_id_table.sv
dv/hashed_request_id_table_test.sv
